### rtl/core/gse_pkg.sv
// Shared types and constants for the gnome sort engine.
package gse_pkg;

  localparam int DEPTH_DEFAULT     = 64;
  localparam int KEY_WIDTH_DEFAULT = 32;
  localparam int IO_KEY_WIDTH      = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_SWAP,
    ST_OUT_RD,
    ST_OUT_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // store the incoming key
    logic rd_pair;   // read entries pos and pos-1
    logic swap_lo;   // write current key to pos-1
    logic swap_hi;   // write predecessor to pos, step back
    logic advance;   // step forward
    logic rd_out;    // read entry pos for output
    logic emit;      // present one result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;     // no keys held
    logic less;      // current key below its predecessor
    logic walk_end;  // next forward step leaves the set
    logic last_key;  // pos is the final stored entry
  } status_t;

endpackage

### rtl/core/gse_ctrl.sv
// Controller state machine of the gnome sort engine.
module gse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              final_key,
  input  gse_pkg::status_t  status,
  output gse_pkg::cmd_t     cmd,
  output logic              busy
);

  gse_pkg::state_t state;
  gse_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != gse_pkg::ST_IDLE);
    case (state)
      gse_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (final_key) begin
            // a lone key needs no walk
            state_next = status.empty ? gse_pkg::ST_OUT_RD : gse_pkg::ST_READ;
          end
        end
      end
      gse_pkg::ST_READ: begin
        cmd.rd_pair = 1'b1;
        state_next  = gse_pkg::ST_CMP;
      end
      gse_pkg::ST_CMP: begin
        if (status.less) begin
          cmd.swap_lo = 1'b1;
          state_next  = gse_pkg::ST_SWAP;
        end else begin
          cmd.advance = 1'b1;
          state_next  = status.walk_end ? gse_pkg::ST_OUT_RD : gse_pkg::ST_READ;
        end
      end
      gse_pkg::ST_SWAP: begin
        cmd.swap_hi = 1'b1;
        state_next  = gse_pkg::ST_READ;
      end
      gse_pkg::ST_OUT_RD: begin
        cmd.rd_out = 1'b1;
        state_next = gse_pkg::ST_OUT_EMIT;
      end
      gse_pkg::ST_OUT_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = status.last_key ? gse_pkg::ST_IDLE : gse_pkg::ST_OUT_RD;
      end
      default: begin
        state_next = gse_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/gse_datapath.sv
// Datapath of the gnome sort engine: key store, pointers and comparator.
module gse_datapath #(
  parameter int DEPTH     = gse_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = gse_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic                             cfg_data,
  input  logic [gse_pkg::IO_KEY_WIDTH-1:0] key_value,
  input  logic                             final_key,
  input  gse_pkg::cmd_t                    cmd,
  output gse_pkg::status_t                 status,
  output logic [gse_pkg::IO_KEY_WIDTH-1:0] sorted_key
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic [KEY_WIDTH-1:0] rd_a;
  logic [KEY_WIDTH-1:0] rd_b;
  logic [CW-1:0]        count;
  logic [CW-1:0]        pos;
  logic                 keys_signed;

  logic [CW-1:0]        pos_inc;
  logic [CW-1:0]        pos_dec;
  logic                 full;
  logic [KEY_WIDTH-1:0] flip;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;

  assign pos_inc = pos + CW'(1);
  assign pos_dec = pos - CW'(1);
  assign full    = (count == CW'(DEPTH));

  always_comb begin
    flip                = '0;
    flip[KEY_WIDTH-1]   = keys_signed;
  end

  assign status.empty    = (count == '0);
  assign status.less     = ((rd_a ^ flip) < (rd_b ^ flip));
  assign status.walk_end = (pos_inc == count);
  assign status.last_key = (pos_inc == count);

  assign sorted_key = gse_pkg::IO_KEY_WIDTH'(rd_a);

  // single write port shared by load and swap
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos[AW-1:0];
    wr_data = rd_b;
    if (cmd.load) begin
      wr_en   = !full;
      wr_addr = count[AW-1:0];
      wr_data = KEY_WIDTH'(key_value);
    end else if (cmd.swap_lo) begin
      wr_en   = 1'b1;
      wr_addr = pos_dec[AW-1:0];
      wr_data = rd_a;
    end else if (cmd.swap_hi) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_pair || cmd.rd_out) begin
      rd_a <= mem[pos[AW-1:0]];
    end
    if (cmd.rd_pair) begin
      rd_b <= mem[pos_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      pos         <= '0;
      keys_signed <= 1'b0;
    end else begin
      if (cfg_write) begin
        keys_signed <= cfg_data;
      end
      if (cmd.load) begin
        if (!full) begin
          count <= pos_inc - pos + count;
        end
        if (final_key) begin
          pos <= (count == '0) ? '0 : CW'(1);
        end
      end
      if (cmd.swap_hi) begin
        // stepping back onto entry zero advances at once to entry one
        pos <= (pos == CW'(1)) ? CW'(1) : pos_dec;
      end
      if (cmd.advance) begin
        pos <= status.walk_end ? '0 : pos_inc;
      end
      if (cmd.emit) begin
        if (status.last_key) begin
          pos   <= '0;
          count <= '0;
        end else begin
          pos <= pos_inc;
        end
      end
    end
  end

endmodule

### rtl/core/gnome_sort_engine.sv
// Top level of the gnome sort engine: controller plus datapath.
//
// Keys are loaded one item per cycle while busy is low: an item is taken at a
// rising edge with start high and busy low, and keys past DEPTH are dropped.
// An item with final_key set starts the sort and raises busy. Each forward
// step of the walk is a store read, then a compare; a swap adds a second
// write state after the compare, as the key store has a single write port.
// The sorted keys then leave in ascending order, each through a store read
// and then a present state; each is shown on sorted_key for exactly one
// cycle with result_strobe high, and last_out marks the final one. The
// receiver cannot stall this stream and must take every result as it
// appears. busy falls the cycle after the final result. keys_signed selects
// unsigned or two's complement comparison; the user must write it through
// cfg_write and cfg_data only while the block is idle, and the block
// itself does not enforce this. No clearing pass follows reset.
module gnome_sort_engine #(
  parameter int DEPTH     = gse_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = gse_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic                             cfg_data,
  input  logic                             start,
  output logic                             busy,
  input  logic [gse_pkg::IO_KEY_WIDTH-1:0] key_value,
  input  logic                             final_key,
  output logic                             result_strobe,
  output logic [gse_pkg::IO_KEY_WIDTH-1:0] sorted_key,
  output logic                             last_out
);

  gse_pkg::cmd_t    cmd;
  gse_pkg::status_t status;

  // sequence load, walk and drain
  gse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .final_key (final_key),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // hold keys and do the compare and swap work
  gse_datapath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .key_value  (key_value),
    .final_key  (final_key),
    .cmd        (cmd),
    .status     (status),
    .sorted_key (sorted_key)
  );

  assign result_strobe = cmd.emit;
  assign last_out      = cmd.emit && status.last_key;

`ifndef NO_ASSERTIONS
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result strobe outside a sort");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last_out) |=> !busy)
    else $error("block still busy after final result");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ($past(start) && $past(final_key)))
    else $error("busy rose without a final item");

  a_no_double: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("results closer than one store read apart");
`endif

endmodule

### bench/sort_check_pkg.sv
// Scoreboard class: predicts the sorted key stream and checks each result against it.
`timescale 1ns / 100ps
package sort_check_pkg;

  class sort_checker;
    bit          signed_mode;
    logic [31:0] held_keys[$];
    logic [31:0] expected_keys[$];
    bit          expected_final[$];
    int          mismatches;

    function void set_signed(bit mode);
      signed_mode = mode;
    endfunction

    function bit key_below(logic [31:0] a, logic [31:0] b);
      if (signed_mode) begin
        return $signed(a) < $signed(b);
      end
      return a < b;
    endfunction

    // Hold the key while there is room; on a final item walk the held set
    // with gnome sort and queue the sorted run.
    function void note_item(logic [31:0] key, bit fin);
      logic [31:0] run[$];
      logic [31:0] tmp;
      int          pos;
      if (held_keys.size() < gse_pkg::DEPTH_DEFAULT) begin
        held_keys.push_back(key);
      end
      if (!fin) begin
        return;
      end
      run = held_keys;
      pos = 0;
      while (pos < run.size()) begin
        if (pos != 0 && key_below(run[pos], run[pos-1])) begin
          tmp         = run[pos];
          run[pos]    = run[pos-1];
          run[pos-1]  = tmp;
          pos--;
        end else begin
          pos++;
        end
      end
      foreach (run[k]) begin
        expected_keys.push_back(run[k]);
        expected_final.push_back(k == run.size() - 1);
      end
      held_keys.delete();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [31:0] key, logic fin);
      logic [31:0] want_key;
      bit          want_final;
      if (expected_keys.size() == 0) begin
        report_mismatch($sformatf("unexpected key %h last_out %b", key, fin));
        return;
      end
      want_key   = expected_keys.pop_front();
      want_final = expected_final.pop_front();
      if (key !== want_key) begin
        report_mismatch($sformatf("sorted_key %h, want %h", key, want_key));
      end
      if (fin !== want_final) begin
        report_mismatch($sformatf("last_out %b, want %b (key %h)", fin, want_final, want_key));
      end
    endtask

    function int pending();
      return expected_keys.size();
    endfunction
  endclass

endpackage

### bench/tb_top.sv
// Top-level testbench for gnome_sort_engine: directed and random key sets.
`timescale 1ns / 100ps
module tb_top;

  logic                             clk;
  logic                             rst;
  logic                             cfg_write;
  logic                             cfg_data;
  logic                             start;
  logic                             busy;
  logic [gse_pkg::IO_KEY_WIDTH-1:0] key_value;
  logic                             final_key;
  logic                             result_strobe;
  logic [gse_pkg::IO_KEY_WIDTH-1:0] sorted_key;
  logic                             last_out;

  sort_check_pkg::sort_checker sb;
  int          items_sent;
  int          burst_left;

  gnome_sort_engine uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .key_value     (key_value),
    .final_key     (final_key),
    .result_strobe (result_strobe),
    .sorted_key    (sorted_key),
    .last_out      (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch every edge: track register writes, note accepted items and check
  // results. Values read here are the ones that held before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) begin
        sb.set_signed(cfg_data);
      end
      if (start && !busy) begin
        sb.note_item(key_value, final_key);
      end
      if (result_strobe) begin
        sb.check_result(sorted_key, last_out);
      end
    end
  end

  // Present one item at the falling edge and hold it until the block takes it.
  task automatic send_key(logic [31:0] key, bit fin);
    @(negedge clk);
    start     <= 1'b1;
    key_value <= key;
    final_key <= fin;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Drop start and wiggle the idle payload with fresh random values.
  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      start     <= 1'b0;
      key_value <= $urandom;
      final_key <= $urandom_range(0, 1);
    end
  endtask

  // Close a burst now and then: usually a short gap, sometimes none at all.
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) begin
        idle_for($urandom_range(1, 6));
      end
      burst_left = $urandom_range(1, 8);
    end
  endtask

  // Drop start, wait until every queued result has come out and busy is low,
  // then let the pipeline drain a little before touching the register.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0 || busy) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_signed(bit mode);
    @(negedge clk);
    start     <= 1'b0;
    cfg_write <= 1'b1;
    cfg_data  <= mode;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key(int style);
    logic [31:0] corners[4];
    corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    case (style)
      0: begin
        return $urandom;
      end
      1: begin
        // Narrow range: plenty of equal keys.
        return $urandom_range(0, 7);
      end
      2: begin
        // Small values around zero, both signs.
        return $urandom_range(0, 15) - 8;
      end
      default: begin
        return corners[$urandom_range(0, 3)];
      end
    endcase
  endfunction

  // Send one set of n keys, the final one marked. Order: random, rising
  // (sorted unless keys wrap) or falling (worst walk case unless keys wrap).
  task automatic run_set(int n, int style, int order);
    logic [31:0] base;
    logic [31:0] step;
    logic [31:0] key;
    base = $urandom;
    step = $urandom_range(1, 1000);
    for (int i = 0; i < n; i++) begin
      case (order)
        1:       key = base + i * step;
        2:       key = base - i * step;
        default: key = pick_key(style);
      endcase
      send_key(key, i == n - 1);
      pace();
    end
  endtask

  initial begin
    int n;
    sb         = new();
    items_sent = 0;
    burst_left = 4;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_data   = 1'b0;
    start      = 1'b0;
    key_value  = '0;
    final_key  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Unsigned: field extremes, the all-ones key must come out last.
    write_signed(1'b0);
    send_key(32'h7FFF_FFFF, 1'b0);
    send_key(32'hFFFF_FFFF, 1'b0);
    send_key(32'h0000_0000, 1'b0);
    send_key(32'h8000_0000, 1'b1);

    // Signed: the same extremes, now the most negative key leads.
    settle();
    write_signed(1'b1);
    send_key(32'hFFFF_FFFF, 1'b0);
    send_key(32'h7FFF_FFFF, 1'b0);
    send_key(32'h8000_0000, 1'b0);
    send_key(32'h0000_0000, 1'b0);
    send_key(32'h0000_0001, 1'b1);

    // A set of one key, and a set with repeated keys.
    send_key(32'hA5A5_A5A5, 1'b1);
    send_key(32'h0000_0005, 1'b0);
    send_key(32'h0000_0003, 1'b0);
    send_key(32'h0000_0005, 1'b1);

    // Back to unsigned with a short falling run.
    settle();
    write_signed(1'b0);
    for (int i = 0; i < 8; i++) begin
      send_key(32'hF000_0000 - i * 32'h1111_1111, i == 7);
    end

    // Overfill the store: the last three keys are dropped, the final one
    // among them, and the sort still runs over the full store.
    run_set(67, 0, 0);

    // Random sets: mostly small, a few near, at or past full depth.
    while (items_sent < 330) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        write_signed($urandom_range(0, 1));
      end
      if ($urandom_range(0, 24) == 0) begin
        n = $urandom_range(62, 68);
      end else begin
        n = $urandom_range(1, 12);
      end
      run_set(n, $urandom_range(0, 3), $urandom_range(0, 5) < 4 ? 0 : $urandom_range(1, 2));
    end

    idle_for(1);
    while (sb.pending() != 0 || busy) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[gnome_sort_engine] OK");
    end else begin
      $display("[gnome_sort_engine] ERROR");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("[gnome_sort_engine] ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/core/gse_pkg.sv
rtl/core/gse_ctrl.sv
rtl/core/gse_datapath.sv
rtl/core/gnome_sort_engine.sv
bench/sort_check_pkg.sv
bench/tb_top.sv
